// ===== sv/capped_distinct_value_histogram_defines.svh =====
// assertion helpers for the checker file
`ifndef CAPPED_DISTINCT_VALUE_HISTOGRAM_DEFINES_SVH
`define CAPPED_DISTINCT_VALUE_HISTOGRAM_DEFINES_SVH

// generic form with explicit clock and active-low reset
`define CDVH_ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// house form on clk_i and rst_ni
`define CDVH_ASSERT(label, prop, msg) \
  `CDVH_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ===== sv/cdvh_pkg.sv =====
package cdvh_pkg;

  // request command carried in s_axis_tuser
  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  // result kind carried in m_axis_tuser
  typedef enum logic [2:0] {
    KIND_HIT   = 3'd0,
    KIND_NEW   = 3'd1,
    KIND_DROP  = 3'd2,
    KIND_READ  = 3'd3,
    KIND_RANGE = 3'd4,
    KIND_CLEAR = 3'd5
  } kind_e;

  // sequencer states of the top level
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_RED1,
    ST_RED2,
    ST_APPLY
  } state_e;

  localparam int CmdW       = 2;
  localparam int KindW      = 3;
  localparam int LabelW     = 32;
  localparam int IndexW     = 8;
  localparam int OutCountW  = 32;
  localparam int UsedOutW   = 9;
  localparam int InDataW    = 40;
  localparam int OutDataW   = 80;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic eval;    // latch compare results and the contribution of the selected cell
    logic sample;  // current request is a sample
    logic read;    // current request is a read
    logic insert;  // shift right of insertion point, write new label
    logic incr;    // bump count of the matching cell
  } cell_ctrl_t;

endpackage

// ===== sv/cdvh_cell.sv =====
module cdvh_cell #(
  parameter int VALUE_BITS = 32,
  parameter int COUNT_BITS = 32,
  parameter int USED_W     = 9,
  parameter int INDEX      = 0
) (
  input  logic                           clk_i,
  input  cdvh_pkg::cell_ctrl_t           ctrl_i,
  input  logic [VALUE_BITS-1:0]          sample_i,
  input  logic [cdvh_pkg::IndexW-1:0]    read_index_i,
  input  logic [USED_W-1:0]              used_i,
  input  logic                           left_lt_i,
  input  logic [VALUE_BITS-1:0]          left_label_i,
  input  logic [COUNT_BITS-1:0]          left_count_i,
  output logic                           lt_o,
  output logic [VALUE_BITS-1:0]          label_o,
  output logic [COUNT_BITS-1:0]          count_o,
  output logic [VALUE_BITS+COUNT_BITS:0] contrib_o
);

  logic [VALUE_BITS-1:0]          label_q, label_d;
  logic [COUNT_BITS-1:0]          count_q, count_d;
  logic                           lt_q, lt_d;
  logic                           eq_q, eq_d;
  logic [VALUE_BITS+COUNT_BITS:0] contrib_q, contrib_d;
  logic                           valid;
  logic                           sel;

  // entries below the fill count hold live labels
  assign valid = USED_W'(INDEX) < used_i;

  always_comb begin
    lt_d      = lt_q;
    eq_d      = eq_q;
    contrib_d = contrib_q;
    label_d   = label_q;
    count_d   = count_q;
    sel       = 1'b0;
    if (ctrl_i.eval) begin
      lt_d = valid && ($signed(label_q) < $signed(sample_i));
      eq_d = valid && (label_q == sample_i);
      if (ctrl_i.sample) begin
        sel = eq_d;
      end else if (ctrl_i.read) begin
        sel = valid && (32'(read_index_i) == INDEX);
      end
      contrib_d = sel ? {1'b1, label_q, count_q} : '0;
    end
    if (ctrl_i.incr && eq_q && (count_q != '1)) begin
      count_d = count_q + COUNT_BITS'(1);
    end
    if (ctrl_i.insert && !lt_q) begin
      if (left_lt_i) begin
        label_d = sample_i;
        count_d = COUNT_BITS'(1);
      end else begin
        label_d = left_label_i;
        count_d = left_count_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lt_q      <= lt_d;
    eq_q      <= eq_d;
    contrib_q <= contrib_d;
    label_q   <= label_d;
    count_q   <= count_d;
  end

  assign lt_o      = lt_q;
  assign label_o   = label_q;
  assign count_o   = count_q;
  assign contrib_o = contrib_q;

endmodule

// ===== sv/cdvh_reduce.sv =====
module cdvh_reduce #(
  parameter int W = 65,
  parameter int N = 256
) (
  input  logic         clk_i,
  input  logic [W-1:0] in_i [N],
  output logic [W-1:0] out_o
);

  localparam int Group  = 64;
  localparam int Groups = (N + Group - 1) / Group;

  logic [W-1:0] grp_d [Groups];
  logic [W-1:0] grp_q [Groups];
  logic [W-1:0] out_d, out_q;

  // first level: or of up to 64 cells per group
  always_comb begin
    for (int g = 0; g < Groups; g++) begin
      grp_d[g] = '0;
      for (int j = 0; j < Group; j++) begin
        if (g * Group + j < N) begin
          grp_d[g] = grp_d[g] | in_i[g * Group + j];
        end
      end
    end
  end

  // second level: or of the group results
  always_comb begin
    out_d = '0;
    for (int g = 0; g < Groups; g++) begin
      out_d = out_d | grp_q[g];
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
    out_q <= out_d;
  end

  assign out_o = out_q;

endmodule

// ===== sv/capped_distinct_value_histogram.sv =====
// channel  dir  handshake                   payload
// s_axis   in   s_axis_tvalid/s_axis_tready  tuser: cmd  tdata: label_value, read_index
// m_axis   out  m_axis_tvalid/m_axis_tready  tuser: kind tdata: entry_value, entry_count,
//                                              entries_used, truncated
//
// a request passes through cell compare, two levels of the or tree that collects the
// matching cell, then the update of the cell row together with loading the output register;
// no new request is taken until the current one is done
// a stalled output holds the request in the update state; no new request is taken
// reset clears the sequencer, the fill count, the truncated flag and the output valid
// cell contents are not reset; cells at or beyond the fill count are never selected
module capped_distinct_value_histogram #(
  parameter int CAPACITY   = 256,
  parameter int VALUE_BITS = 32,
  parameter int COUNT_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [31:0] label_value, [39:32] read_index
  input  logic [cdvh_pkg::InDataW-1:0]    s_axis_tdata,
  // [1:0] cmd
  input  logic [cdvh_pkg::CmdW-1:0]       s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [31:0] entry_value, [63:32] entry_count, [72:64] entries_used, [73] truncated
  output logic [cdvh_pkg::OutDataW-1:0]   m_axis_tdata,
  // [2:0] kind
  output logic [cdvh_pkg::KindW-1:0]      m_axis_tuser
);

  localparam int UsedW = $clog2(CAPACITY + 1);
  localparam int CW    = VALUE_BITS + COUNT_BITS + 1;

  cdvh_pkg::state_e                 state_q, state_d;
  cdvh_pkg::cmd_e                   cmd_q;
  logic [VALUE_BITS-1:0]            sample_q;
  logic [cdvh_pkg::IndexW-1:0]      index_q;
  logic [UsedW-1:0]                 used_q, used_d;
  logic                             trunc_q, trunc_d;
  logic                             m_valid_q, m_valid_d;
  logic [cdvh_pkg::OutDataW-1:0]    m_data_q, m_data_d;
  cdvh_pkg::kind_e                  m_kind_q, m_kind_d;
  cdvh_pkg::cell_ctrl_t             ctrl;
  logic                             accept;
  logic                             out_free;
  logic [VALUE_BITS-1:0]            sample_in;

  // cell row wiring, one extra slot on the left feeds cell zero
  logic                             lt_w    [CAPACITY+1];
  logic [VALUE_BITS-1:0]            label_w [CAPACITY+1];
  logic [COUNT_BITS-1:0]            count_w [CAPACITY+1];
  logic [CW-1:0]                    contrib [CAPACITY];
  logic [CW-1:0]                    red;

  logic                             red_hit;
  logic [VALUE_BITS-1:0]            red_label;
  logic [COUNT_BITS-1:0]            red_count;
  logic [COUNT_BITS-1:0]            hit_count;
  logic [VALUE_BITS-1:0]            res_label;
  logic [COUNT_BITS-1:0]            res_count;
  logic [cdvh_pkg::LabelW-1:0]      res_label32;
  logic [cdvh_pkg::OutCountW-1:0]   res_count32;
  logic                             full;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == cdvh_pkg::ST_IDLE);
  assign out_free      = !m_valid_q || m_axis_tready;
  assign full          = (used_q == UsedW'(CAPACITY));

  // label narrowed or sign-extended to the table width
  if (VALUE_BITS <= cdvh_pkg::LabelW) begin : g_in_narrow
    assign sample_in = s_axis_tdata[VALUE_BITS-1:0];
  end else begin : g_in_wide
    assign sample_in = {{(VALUE_BITS - cdvh_pkg::LabelW){s_axis_tdata[cdvh_pkg::LabelW-1]}},
                        s_axis_tdata[cdvh_pkg::LabelW-1:0]};
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= cdvh_pkg::cmd_e'(s_axis_tuser);
      sample_q <= sample_in;
      index_q  <= s_axis_tdata[cdvh_pkg::LabelW +: cdvh_pkg::IndexW];
    end
  end

  // row of cells, each takes its left neighbor on insertion
  assign lt_w[0]    = 1'b1;
  assign label_w[0] = sample_q;
  assign count_w[0] = COUNT_BITS'(1);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cdvh_cell #(
      .VALUE_BITS (VALUE_BITS),
      .COUNT_BITS (COUNT_BITS),
      .USED_W     (UsedW),
      .INDEX      (i)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .sample_i     (sample_q),
      .read_index_i (index_q),
      .used_i       (used_q),
      .left_lt_i    (lt_w[i]),
      .left_label_i (label_w[i]),
      .left_count_i (count_w[i]),
      .lt_o         (lt_w[i+1]),
      .label_o      (label_w[i+1]),
      .count_o      (count_w[i+1]),
      .contrib_o    (contrib[i])
    );
  end

  // collects the single selected cell over two registered levels
  cdvh_reduce #(
    .W (CW),
    .N (CAPACITY)
  ) u_reduce (
    .clk_i (clk_i),
    .in_i  (contrib),
    .out_o (red)
  );

  assign red_hit   = red[CW-1];
  assign red_label = red[COUNT_BITS +: VALUE_BITS];
  assign red_count = red[COUNT_BITS-1:0];
  assign hit_count = (red_count == '1) ? red_count : red_count + COUNT_BITS'(1);

  // result fields widened or cut to the port widths
  if (VALUE_BITS >= cdvh_pkg::LabelW) begin : g_out_label_cut
    assign res_label32 = res_label[cdvh_pkg::LabelW-1:0];
  end else begin : g_out_label_ext
    assign res_label32 = {{(cdvh_pkg::LabelW - VALUE_BITS){res_label[VALUE_BITS-1]}},
                          res_label};
  end
  if (COUNT_BITS >= cdvh_pkg::OutCountW) begin : g_out_count_cut
    assign res_count32 = res_count[cdvh_pkg::OutCountW-1:0];
  end else begin : g_out_count_ext
    assign res_count32 = {{(cdvh_pkg::OutCountW - COUNT_BITS){1'b0}}, res_count};
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    used_d    = used_q;
    trunc_d   = trunc_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    m_kind_d  = m_kind_q;
    ctrl      = '0;
    res_label = '0;
    res_count = '0;
    ctrl.sample = (cmd_q == cdvh_pkg::CMD_SAMPLE);
    ctrl.read   = (cmd_q == cdvh_pkg::CMD_READ);
    unique case (state_q)
      cdvh_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = cdvh_pkg::ST_EVAL;
        end
      end
      cdvh_pkg::ST_EVAL: begin
        ctrl.eval = 1'b1;
        state_d   = cdvh_pkg::ST_RED1;
      end
      cdvh_pkg::ST_RED1: begin
        state_d = cdvh_pkg::ST_RED2;
      end
      cdvh_pkg::ST_RED2: begin
        state_d = cdvh_pkg::ST_APPLY;
      end
      cdvh_pkg::ST_APPLY: begin
        unique case (cmd_q)
          cdvh_pkg::CMD_SAMPLE: begin
            if (out_free) begin
              state_d   = cdvh_pkg::ST_IDLE;
              m_valid_d = 1'b1;
              if (red_hit) begin
                ctrl.incr = 1'b1;
                m_kind_d  = cdvh_pkg::KIND_HIT;
                res_label = sample_q;
                res_count = hit_count;
              end else if (full) begin
                trunc_d  = 1'b1;
                m_kind_d = cdvh_pkg::KIND_DROP;
              end else begin
                ctrl.insert = 1'b1;
                used_d      = used_q + UsedW'(1);
                m_kind_d    = cdvh_pkg::KIND_NEW;
                res_label   = sample_q;
                res_count   = COUNT_BITS'(1);
              end
            end
          end
          cdvh_pkg::CMD_READ: begin
            if (out_free) begin
              state_d   = cdvh_pkg::ST_IDLE;
              m_valid_d = 1'b1;
              if (red_hit) begin
                m_kind_d  = cdvh_pkg::KIND_READ;
                res_label = red_label;
                res_count = red_count;
              end else begin
                m_kind_d = cdvh_pkg::KIND_RANGE;
              end
            end
          end
          cdvh_pkg::CMD_CLEAR: begin
            if (out_free) begin
              state_d   = cdvh_pkg::ST_IDLE;
              m_valid_d = 1'b1;
              used_d    = '0;
              trunc_d   = 1'b0;
              m_kind_d  = cdvh_pkg::KIND_CLEAR;
            end
          end
          default: begin
            // unused command code: no result
            state_d = cdvh_pkg::ST_IDLE;
          end
        endcase
        if (state_d == cdvh_pkg::ST_IDLE && m_valid_d && out_free) begin
          m_data_d = {{(cdvh_pkg::OutDataW - 2 * cdvh_pkg::LabelW - cdvh_pkg::UsedOutW - 1){1'b0}},
                      trunc_d, cdvh_pkg::UsedOutW'(used_d), res_count32, res_label32};
        end
      end
      default: begin
        state_d = cdvh_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= cdvh_pkg::ST_IDLE;
      used_q    <= '0;
      trunc_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      trunc_q   <= trunc_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    m_kind_q <= m_kind_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_kind_q;

endmodule

// ===== sv/cdvh_checker.sv =====
`include "capped_distinct_value_histogram_defines.svh"

module cdvh_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [cdvh_pkg::InDataW-1:0]  s_axis_tdata,
  input logic [cdvh_pkg::CmdW-1:0]     s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [cdvh_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [cdvh_pkg::KindW-1:0]    m_axis_tuser
);

  logic drop_out;
  logic clear_out;
  logic in_busy;

  assign drop_out  = m_axis_tvalid && (m_axis_tuser == cdvh_pkg::KIND_DROP);
  assign clear_out = m_axis_tvalid && (m_axis_tuser == cdvh_pkg::KIND_CLEAR);
  assign in_busy   = s_axis_tvalid && s_axis_tready && (s_axis_tuser != 2'd3);

  // a dropped label always raises the sticky flag in the same result
  `CDVH_ASSERT(a_drop_sets_flag, drop_out |-> m_axis_tdata[73], "drop without truncated flag")

  // a clear result reports an empty table with the flag down
  `CDVH_ASSERT(a_clear_empty, clear_out |-> (m_axis_tdata[72:64] == 9'd0) && !m_axis_tdata[73], "clear not empty")

  // a request that yields a result keeps the input closed on the next cycle
  `CDVH_ASSERT(a_one_at_a_time, in_busy |=> !s_axis_tready, "input open while busy")

  // stalled result holds
  `CDVH_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind capped_distinct_value_histogram cdvh_checker u_cdvh_checker (.*);
